/* src/ign3_pkg.sv */
`timescale 1ns / 1ps

package ign3_pkg;

  // default fraction width of the Q16.16 coordinates
  localparam int FRAC_BITS_DEF = 16;

  // permutation table
  localparam int PERM_DEPTH = 256;
  localparam int PERM_W     = 8;

  // result format, signed Q2.16
  localparam int OUT_W    = 18;
  localparam int OUT_FRAC = 16;
  localparam int OUT_MAX  = 131071;
  localparam int OUT_MIN  = -131072;

  // hash codes that steer the gradient selection
  localparam logic [3:0] HASH_U_SPLIT = 4'd8;
  localparam logic [3:0] HASH_V_SPLIT = 4'd4;
  localparam logic [3:0] HASH_VX_A    = 4'd12;
  localparam logic [3:0] HASH_VX_B    = 4'd14;

  // item operation
  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_EVAL = 1'b1
  } op_t;

  // table write travelling down the lookup pipeline
  typedef struct packed {
    logic                load;
    logic [PERM_W-1:0]   idx;
    logic [PERM_W-1:0]   val;
  } perm_wr_t;

endpackage

/* src/improved_gradient_noise_3d_unit.sv */
`timescale 1ns / 1ps

// Improved 3D gradient noise, one octave, on signed fixed-point coordinates.
// Fully pipelined: one item per clock while not stalled; an evaluate result
// passes the input register, three permutation lookup levels, five fade
// stages overlapped with the gradients, ten blend stages and the output
// register. A load item (op = 0) writes one permutation entry and gives
// no result; the table is held as seven replicated copies (three of 256 x 8 and
// four of 256 x 4, as the last level only needs the low hash bits), one per
// lookup read pair, and each copy is written when the load passes its level,
// so loads and evaluations take effect strictly in item order. Every table
// entry an evaluation touches must have been loaded first. When out_ready is
// low with a result waiting the whole pipeline holds and in_ready drops.

module improved_gradient_noise_3d_unit #(
  parameter int FRAC_BITS = ign3_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_op,
  input  logic signed [31:0]                 in_pos_x,
  input  logic signed [31:0]                 in_pos_y,
  input  logic signed [31:0]                 in_pos_z,
  input  logic [7:0]                         in_entry_index,
  input  logic [7:0]                         in_entry_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [ign3_pkg::OUT_W-1:0]  out_noise_value
);
  import ign3_pkg::*;

  localparam int F     = FRAC_BITS;
  localparam int GW    = F + 3;
  localparam int DEPTH = 13;
  localparam int DN    = (F > OUT_FRAC) ? F - OUT_FRAC : 0;
  localparam int UP    = (F < OUT_FRAC) ? OUT_FRAC - F : 0;
  localparam int CW    = GW + UP + 1;
  localparam logic signed [CW-1:0] RND    = CW'((longint'(1) << DN) >> 1);
  localparam logic signed [CW-1:0] SAT_HI = CW'(OUT_MAX);
  localparam logic signed [CW-1:0] SAT_LO = CW'(OUT_MIN);

  logic                     adv;
  logic [DEPTH:0]           ev_r;
  perm_wr_t                 wr0_r;
  logic [31:0]              px0_r, py0_r, pz0_r;
  logic                     out_valid_r;
  logic signed [OUT_W-1:0]  out_value_r;

  logic [F-1:0]             frac [3];
  logic [3:0]               hash [8];
  logic [F:0]               weight [3];
  logic signed [GW-1:0]     value;
  logic signed [CW-1:0]     conv;
  logic signed [OUT_W-1:0]  sat_nxt;

  // the whole pipeline moves unless a result is held
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  // input stage and item flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev_r        <= '0;
      wr0_r.load  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      ev_r[0]     <= in_valid && (in_op == OP_EVAL);
      for (int k = 1; k <= DEPTH; k++) begin
        ev_r[k] <= ev_r[k - 1];
      end
      wr0_r.load  <= in_valid && (in_op == OP_LOAD);
      wr0_r.idx   <= in_entry_index;
      wr0_r.val   <= in_entry_value;
      out_valid_r <= ev_r[DEPTH];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      px0_r       <= in_pos_x;
      py0_r       <= in_pos_y;
      pz0_r       <= in_pos_z;
      out_value_r <= sat_nxt;
    end
  end

  // fraction of each coordinate
  assign frac[0] = px0_r[F-1:0];
  assign frac[1] = py0_r[F-1:0];
  assign frac[2] = pz0_r[F-1:0];

  ign3_hash u_hash (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .wr_i     (wr0_r),
    .cell_x_i (px0_r[F+7:F]),
    .cell_y_i (py0_r[F+7:F]),
    .cell_z_i (pz0_r[F+7:F]),
    .hash_o   (hash)
  );

  ign3_fade #(
    .FRAC_BITS (FRAC_BITS)
  ) u_fade (
    .clk      (clk),
    .adv      (adv),
    .frac_i   (frac),
    .weight_o (weight)
  );

  ign3_blend #(
    .FRAC_BITS (FRAC_BITS)
  ) u_blend (
    .clk      (clk),
    .adv      (adv),
    .frac_i   (frac),
    .hash_i   (hash),
    .weight_i (weight),
    .value_o  (value)
  );

  // rescale to Q2.16 and saturate
  always_comb begin
    conv = ((CW'(value) <<< UP) + RND) >>> DN;
    if (conv > SAT_HI) begin
      sat_nxt = OUT_W'(SAT_HI);
    end else if (conv < SAT_LO) begin
      sat_nxt = OUT_W'(SAT_LO);
    end else begin
      sat_nxt = conv[OUT_W-1:0];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_noise_value = out_value_r;

`ifndef ASSERT_OFF
  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_op == OP_LOAD) |=> !ev_r[0])
    else $error("load item entered the result pipeline");

  a_eval_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_op == OP_EVAL) |=> (ev_r[0] && !wr0_r.load))
    else $error("evaluate item lost at the input stage");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |=> ($stable(ev_r) && $stable(out_value_r)))
    else $error("pipeline moved while stalled");

  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    !(ev_r[0] && wr0_r.load))
    else $error("input stage holds both a load and an evaluation");
`endif

endmodule

/* src/ign3_hash.sv */
`timescale 1ns / 1ps

module ign3_hash (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  ign3_pkg::perm_wr_t  wr_i,
  input  logic [7:0]          cell_x_i,
  input  logic [7:0]          cell_y_i,
  input  logic [7:0]          cell_z_i,
  output logic [3:0]          hash_o [8]
);
  import ign3_pkg::*;

  // one table copy per lookup read pair (one, two and four copies per level); each copy has two read ports
  logic [PERM_W-1:0] perm_l1_r [PERM_DEPTH];
  logic [PERM_W-1:0] perm_l2_r [2][PERM_DEPTH];
  logic [3:0]        perm_l3_r [4][PERM_DEPTH];

  perm_wr_t          wr1_r, wr2_r;
  logic [7:0]        cy1_r, cz1_r, cz2_r;
  logic [7:0]        h1_r [2];
  logic [7:0]        h2_r [4];
  logic [3:0]        h3_r [8];

  logic [7:0]        cx_nxt;
  logic [7:0]        base2 [2];
  logic [7:0]        base2_inc [2];
  logic [7:0]        base3 [4];
  logic [7:0]        base3_inc [4];

  // lookup addresses, all wrapping modulo 256
  always_comb begin
    cx_nxt = cell_x_i + 8'd1;
    for (int j = 0; j < 2; j++) begin
      base2[j]     = h1_r[j] + cy1_r;
      base2_inc[j] = base2[j] + 8'd1;
    end
    for (int k = 0; k < 4; k++) begin
      base3[k]     = h2_r[k] + cz2_r;
      base3_inc[k] = base3[k] + 8'd1;
    end
  end

  // loads follow the evaluations so every copy is updated in item order
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr1_r.load <= 1'b0;
      wr2_r.load <= 1'b0;
    end else if (adv) begin
      wr1_r <= wr_i;
      wr2_r <= wr1_r;
    end
  end

  // table copies and registered reads
  always_ff @(posedge clk) begin
    if (adv) begin
      if (wr_i.load) begin
        perm_l1_r[wr_i.idx] <= wr_i.val;
      end
      if (wr1_r.load) begin
        for (int j = 0; j < 2; j++) begin
          perm_l2_r[j][wr1_r.idx] <= wr1_r.val;
        end
      end
      if (wr2_r.load) begin
        for (int k = 0; k < 4; k++) begin
          perm_l3_r[k][wr2_r.idx] <= wr2_r.val[3:0];
        end
      end

      h1_r[0] <= perm_l1_r[cell_x_i];
      h1_r[1] <= perm_l1_r[cx_nxt];
      cy1_r   <= cell_y_i;
      cz1_r   <= cell_z_i;
      cz2_r   <= cz1_r;

      // copy 0 serves a and a+1, copy 1 serves b and b+1
      for (int j = 0; j < 2; j++) begin
        h2_r[j]     <= perm_l2_r[j][base2[j]];
        h2_r[j + 2] <= perm_l2_r[j][base2_inc[j]];
      end

      // corner order: x in bit 0, y in bit 1, z in bit 2
      for (int k = 0; k < 4; k++) begin
        h3_r[k]     <= perm_l3_r[k][base3[k]];
        h3_r[k + 4] <= perm_l3_r[k][base3_inc[k]];
      end
    end
  end

  assign hash_o = h3_r;

endmodule

/* src/ign3_fade.sv */
`timescale 1ns / 1ps

module ign3_fade #(
  parameter int FRAC_BITS = ign3_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 adv,
  input  logic [FRAC_BITS-1:0] frac_i [3],
  output logic [FRAC_BITS:0]   weight_o [3]
);
  import ign3_pkg::*;

  localparam int F    = FRAC_BITS;
  localparam int SQW  = 2 * F;
  localparam int SUMW = 2 * F + 1;
  localparam int QW   = F + 5;
  localparam int PW   = 2 * F + 4;
  localparam int PSW  = 2 * F + 5;
  localparam int WFW  = F + 5;
  localparam longint unsigned HALF = longint'(1) << (F - 1);
  localparam longint unsigned ONE  = longint'(1) << F;

  logic [SQW-1:0] sq1_r   [3];
  logic [F-1:0]   t1_r    [3];
  logic [SQW-1:0] cube2_r [3];
  logic [F-1:0]   t2_2_r  [3];
  logic [F-1:0]   t_2_r   [3];
  logic [F-1:0]   t3_3_r  [3];
  logic [F+3:0]   q3_r    [3];
  logic [PW-1:0]  prod4_r [3];
  logic [F:0]     w5_r    [3];

  logic [SUMW-1:0] sq_sum   [3];
  logic [F-1:0]    t2_c     [3];
  logic [SUMW-1:0] cube_sum [3];
  logic [F-1:0]    t3_c     [3];
  logic [QW-1:0]   q_c      [3];
  logic [PSW-1:0]  p_sum    [3];
  logic [WFW-1:0]  w_full   [3];

  // rounding and polynomial terms, per lane
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      sq_sum[l]   = SUMW'(sq1_r[l]) + SUMW'(HALF);
      t2_c[l]     = sq_sum[l][SQW-1:F];
      cube_sum[l] = SUMW'(cube2_r[l]) + SUMW'(HALF);
      t3_c[l]     = cube_sum[l][SQW-1:F];
      // 6t^2 - 15t + 10, never negative on [0, 1)
      q_c[l]      = QW'(t2_2_r[l]) * QW'(6) + QW'(ONE) * QW'(10)
                    - QW'(t_2_r[l]) * QW'(15);
      p_sum[l]    = PSW'(prod4_r[l]) + PSW'(HALF);
      w_full[l]   = p_sum[l][PSW-1:F];
    end
  end

  // five stages: t^2, t^3, polynomial, product, round and clamp
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 3; l++) begin
        sq1_r[l]   <= SQW'(frac_i[l]) * SQW'(frac_i[l]);
        t1_r[l]    <= frac_i[l];
        cube2_r[l] <= SQW'(t2_c[l]) * SQW'(t1_r[l]);
        t2_2_r[l]  <= t2_c[l];
        t_2_r[l]   <= t1_r[l];
        t3_3_r[l]  <= t3_c[l];
        q3_r[l]    <= q_c[l][F+3:0];
        prod4_r[l] <= PW'(t3_3_r[l]) * PW'(q3_r[l]);
        w5_r[l]    <= (w_full[l] > WFW'(ONE)) ? (F+1)'(ONE) : w_full[l][F:0];
      end
    end
  end

  assign weight_o = w5_r;

endmodule

/* src/ign3_blend.sv */
`timescale 1ns / 1ps

module ign3_blend #(
  parameter int FRAC_BITS = ign3_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        adv,
  input  logic [FRAC_BITS-1:0]        frac_i [3],
  input  logic [3:0]                  hash_i [8],
  input  logic [FRAC_BITS:0]          weight_i [3],
  output logic signed [FRAC_BITS+2:0] value_o
);
  import ign3_pkg::*;

  localparam int F  = FRAC_BITS;
  localparam int GW = F + 3;
  localparam int DW = F + 4;
  localparam int WW = F + 2;
  localparam int PW = DW + WW;
  localparam logic signed [GW-1:0] ONE_G  = GW'(longint'(1) << F);
  localparam logic signed [PW-1:0] HALF_P = PW'(longint'(1) << (F - 1));

  // fractions wait for the hashes
  logic [F-1:0]           fr1_r [3];
  logic [F-1:0]           fr2_r [3];
  logic [F-1:0]           fr3_r [3];
  // weights wait for their lerp level
  logic [F:0]             wy_d_r [3];
  logic [F:0]             wz_d_r [6];

  logic signed [GW-1:0]   g4_r  [8];
  logic signed [DW-1:0]   d5_r  [4];
  logic signed [GW-1:0]   a5_r  [4];
  logic signed [PW-1:0]   p6_r  [4];
  logic signed [GW-1:0]   a6_r  [4];
  logic signed [GW-1:0]   l7_r  [4];
  logic signed [DW-1:0]   d8_r  [2];
  logic signed [GW-1:0]   a8_r  [2];
  logic signed [PW-1:0]   p9_r  [2];
  logic signed [GW-1:0]   a9_r  [2];
  logic signed [GW-1:0]   m10_r [2];
  logic signed [DW-1:0]   d11_r;
  logic signed [GW-1:0]   a11_r;
  logic signed [PW-1:0]   p12_r;
  logic signed [GW-1:0]   a12_r;
  logic signed [GW-1:0]   res13_r;

  logic signed [GW-1:0]   ox [2];
  logic signed [GW-1:0]   oy [2];
  logic signed [GW-1:0]   oz [2];
  logic signed [GW-1:0]   g_c [8];
  logic signed [PW-1:0]   l_sum [4];
  logic signed [PW-1:0]   m_sum [2];
  logic signed [PW-1:0]   r_sum;
  logic signed [WW-1:0]   wx_s, wy_s, wz_s;

  // gradient +-u +-v picked by the low four hash bits
  function automatic logic signed [GW-1:0] grad(input logic [3:0] h,
                                                input logic signed [GW-1:0] gx,
                                                input logic signed [GW-1:0] gy,
                                                input logic signed [GW-1:0] gz);
    logic signed [GW-1:0] u;
    logic signed [GW-1:0] v;
    u = (h < HASH_U_SPLIT) ? gx : gy;
    if (h < HASH_V_SPLIT) begin
      v = gy;
    end else if (h == HASH_VX_A || h == HASH_VX_B) begin
      v = gx;
    end else begin
      v = gz;
    end
    grad = (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

  // corner offsets and gradients
  always_comb begin
    ox[0] = signed'(GW'(fr3_r[0]));
    oy[0] = signed'(GW'(fr3_r[1]));
    oz[0] = signed'(GW'(fr3_r[2]));
    ox[1] = ox[0] - ONE_G;
    oy[1] = oy[0] - ONE_G;
    oz[1] = oz[0] - ONE_G;
    for (int c = 0; c < 8; c++) begin
      g_c[c] = grad(hash_i[c], ox[c % 2], oy[(c / 2) % 2], oz[c / 4]);
    end
  end

  // lerp rounding: a + floor((p + half) / one)
  always_comb begin
    wx_s = signed'(WW'(weight_i[0]));
    wy_s = signed'(WW'(wy_d_r[2]));
    wz_s = signed'(WW'(wz_d_r[5]));
    for (int i = 0; i < 4; i++) begin
      l_sum[i] = PW'(a6_r[i]) + ((p6_r[i] + HALF_P) >>> F);
    end
    for (int i = 0; i < 2; i++) begin
      m_sum[i] = PW'(a9_r[i]) + ((p9_r[i] + HALF_P) >>> F);
    end
    r_sum = PW'(a12_r) + ((p12_r + HALF_P) >>> F);
  end

  // blend pipeline: along x, then y, then z
  always_ff @(posedge clk) begin
    if (adv) begin
      fr1_r <= frac_i;
      fr2_r <= fr1_r;
      fr3_r <= fr2_r;

      wy_d_r[0] <= weight_i[1];
      for (int k = 1; k < 3; k++) begin
        wy_d_r[k] <= wy_d_r[k - 1];
      end
      wz_d_r[0] <= weight_i[2];
      for (int k = 1; k < 6; k++) begin
        wz_d_r[k] <= wz_d_r[k - 1];
      end

      g4_r <= g_c;
      for (int i = 0; i < 4; i++) begin
        d5_r[i] <= DW'(g4_r[2 * i + 1]) - DW'(g4_r[2 * i]);
        a5_r[i] <= g4_r[2 * i];
        p6_r[i] <= PW'(d5_r[i]) * PW'(wx_s);
        a6_r[i] <= a5_r[i];
        l7_r[i] <= l_sum[i][GW-1:0];
      end

      for (int i = 0; i < 2; i++) begin
        d8_r[i]  <= DW'(l7_r[2 * i + 1]) - DW'(l7_r[2 * i]);
        a8_r[i]  <= l7_r[2 * i];
        p9_r[i]  <= PW'(d8_r[i]) * PW'(wy_s);
        a9_r[i]  <= a8_r[i];
        m10_r[i] <= m_sum[i][GW-1:0];
      end

      d11_r   <= DW'(m10_r[1]) - DW'(m10_r[0]);
      a11_r   <= m10_r[0];
      p12_r   <= PW'(d11_r) * PW'(wz_s);
      a12_r   <= a11_r;
      res13_r <= r_sum[GW-1:0];
    end
  end

  assign value_o = res13_r;

endmodule
